// ===== rtl/core/avba_pkg.sv =====
// shared types and constants of the aligned vector block allocator
`default_nettype none
package avba_pkg;

    localparam int MAP_BITS_DEFAULT = 128;
    localparam int MAX_LOG2         = 6;
    localparam int VEC_W            = 8;
    localparam int CFG_IDX_W        = 2;

    localparam logic [VEC_W-1:0] VECTOR_BASE_RESET = 8'd32;
    localparam logic [VEC_W-1:0] NEXT_VECTOR_RESET = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEXT_VECTOR = 2'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [2:0] size_log2;
        logic [7:0] run_length;
    } in_t;

    typedef struct packed {
        logic             found;
        logic [VEC_W-1:0] vector;
    } out_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EVAL   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/avba_ctrl.sv =====
// sequencing of requests: accept, evaluate, commit and output handshake
`default_nettype none
module avba_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output avba_pkg::cmd_t      cmd
);

    avba_pkg::state_t state_reg;
    avba_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             commit_go;
    logic             accept;

    // commit only when the output register is free or being emptied
    assign commit_go = (state_reg == avba_pkg::ST_COMMIT) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == avba_pkg::ST_IDLE) || commit_go;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load   = accept;
        cmd.eval   = (state_reg == avba_pkg::ST_EVAL);
        cmd.commit = commit_go;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            avba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = avba_pkg::ST_EVAL;
                end
            end
            avba_pkg::ST_EVAL:
            begin
                state_next = avba_pkg::ST_COMMIT;
            end
            avba_pkg::ST_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = accept ? avba_pkg::ST_EVAL : avba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = avba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (commit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= avba_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/avba_datapath.sv =====
// used map, configuration registers, candidate search and result register
`default_nettype none
module avba_datapath
#(
    parameter int MAP_BITS = avba_pkg::MAP_BITS_DEFAULT
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire avba_pkg::cmd_t                    cmd,
    input  wire avba_pkg::in_t                     in_data,
    output avba_pkg::out_t                         out_data,
    input  wire logic                              cfg_we,
    input  wire logic [avba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [avba_pkg::VEC_W-1:0]        cfg_data
);

    localparam int IDX_W     = $clog2(MAP_BITS);
    localparam int MAP_WORDS = (MAP_BITS + 63) / 64;
    localparam int PAD_BITS  = MAP_WORDS * 64;
    localparam int LVLS      = avba_pkg::MAX_LOG2 + 1;

    logic [MAP_BITS-1:0]        map_reg;
    logic [MAP_BITS-1:0]        map_next;
    logic [MAP_BITS-1:0]        cand_reg;
    logic [MAP_BITS-1:0]        cand_next;
    avba_pkg::in_t              op_reg;
    avba_pkg::out_t             res_reg;
    avba_pkg::out_t             res_next;
    logic [avba_pkg::VEC_W-1:0] base_reg;
    logic [avba_pkg::VEC_W-1:0] next_vec_reg;

    logic [PAD_BITS-1:0]        lvl [LVLS];
    logic [MAP_BITS-1:0]        free_pos;
    logic [MAP_BITS-1:0]        run_mask;
    logic signed [10:0]         run_start;
    logic signed [10:0]         run_dist;
    logic [MAP_BITS-1:0]        grp_mask;
    logic [MAP_BITS-1:0]        set_mask;
    logic                       hit;
    logic [IDX_W-1:0]           hit_pos;

    // free-group flags per level, bits past the map end count as used
    always_comb
    begin
        for (int l = 0; l < LVLS; l++)
        begin
            lvl[l] = '0;
        end
        for (int i = 0; i < PAD_BITS; i++)
        begin
            lvl[0][i] = (i < MAP_BITS) ? ~map_reg[i] : 1'b0;
        end
        for (int l = 1; l < LVLS; l++)
        begin
            for (int j = 0; j < (PAD_BITS >> l); j++)
            begin
                lvl[l][j] = lvl[l-1][2*j] & lvl[l-1][2*j+1];
            end
        end
    end

    // aligned start positions whose whole group is free
    always_comb
    begin
        for (int b = 0; b < MAP_BITS; b++)
        begin
            free_pos[b] = 1'b0;
            for (int l = 0; l < LVLS; l++)
            begin
                if ((op_reg.size_log2 == 3'(l)) && ((b & ((1 << l) - 1)) == 0))
                begin
                    free_pos[b] = lvl[l][b >> l];
                end
            end
        end
    end

    // run start may lie below the map, so the distance is signed
    assign run_start = $signed({3'b000, next_vec_reg}) - $signed({3'b000, base_reg});

    always_comb
    begin
        run_dist = '0;
        for (int b = 0; b < MAP_BITS; b++)
        begin
            run_dist    = $signed(11'(b)) - run_start;
            run_mask[b] = !run_dist[10]
                          && (run_dist < $signed({3'b000, op_reg.run_length}));
        end
    end

    assign cand_next = (op_reg.opcode == avba_pkg::OP_RUN) ? run_mask : free_pos;

    // lowest candidate position
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = MAP_BITS - 1; i >= 0; i--)
        begin
            if (cand_reg[i])
            begin
                hit     = 1'b1;
                hit_pos = IDX_W'(i);
            end
        end
    end

    // group bits share the position bits above size_log2
    always_comb
    begin
        for (int i = 0; i < MAP_BITS; i++)
        begin
            grp_mask[i] = hit && (((IDX_W'(i) ^ hit_pos) >> op_reg.size_log2) == '0);
        end
    end

    always_comb
    begin
        if (op_reg.opcode == avba_pkg::OP_RUN)
        begin
            set_mask        = cand_reg;
            res_next.found  = 1'b1;
            res_next.vector = next_vec_reg;
        end
        else
        begin
            set_mask        = grp_mask;
            res_next.found  = hit;
            res_next.vector = hit ? (avba_pkg::VEC_W'(hit_pos) + base_reg) : '0;
        end
        map_next = map_reg | set_mask;
    end

    assign out_data = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg      <= '0;
            base_reg     <= avba_pkg::VECTOR_BASE_RESET;
            next_vec_reg <= avba_pkg::NEXT_VECTOR_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                map_reg <= map_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    avba_pkg::REG_VECTOR_BASE: base_reg     <= cfg_data;
                    avba_pkg::REG_NEXT_VECTOR: next_vec_reg <= cfg_data;
                    default:                   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_data;
        end
        if (cmd.eval)
        begin
            cand_reg <= cand_next;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/aligned_vector_block_allocator_top.sv =====
// Aligned vector block allocator. Holds a map of MAP_BITS interrupt vectors,
// all free after reset. Opcode 0 claims the lowest naturally aligned free
// group of 2^size_log2 vectors and returns its first vector (map bit plus
// vector_base, modulo 256) with found set, or found clear and vector 0 when
// no group fits. Opcode 1 marks run_length vectors from next_vector and
// returns next_vector; bits outside the map are ignored. An accepted
// request is registered, the eval state registers candidates from the map,
// and commit picks the lowest, writes the map and result once the output
// register is free or drained, and takes the next request. Configuration
// registers are written through cfg_we, cfg_index and cfg_data; the user
// must do so only while no request is in flight; the block doesn't enforce it.
`default_nettype none
module aligned_vector_block_allocator_top
#(
    parameter int MAP_BITS = avba_pkg::MAP_BITS_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire avba_pkg::in_t                  in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output avba_pkg::out_t                      out_data,
    input  wire logic                           cfg_we,
    input  wire logic [avba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [avba_pkg::VEC_W-1:0]     cfg_data
);

    avba_pkg::cmd_t cmd;

    avba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    avba_datapath
    #(
        .MAP_BITS (MAP_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire
